// ----- rtl/core/las_pkg.sv -----
package las_pkg;

    localparam int SLOT_BITS  = 3;
    localparam int CNT_BITS   = 4;
    localparam int PROB_BITS  = 25;
    localparam int TIME_BITS  = 32;
    localparam int FB_BITS    = 18;
    localparam int LF_BITS    = 30;
    localparam int SCALE_BITS = 10;
    localparam int PK_BITS    = PROB_BITS + SCALE_BITS;
    localparam int PROD_BITS  = PROB_BITS + LF_BITS;
    localparam int W_BITS     = 2 * TIME_BITS + PK_BITS;

    localparam logic [CNT_BITS-1:0]  MAX_SLOTS = 4'd8;
    localparam logic [PROB_BITS-1:0] PROB_ONE  = 25'd16777216;
    localparam logic [PROB_BITS-1:0] PROB_MAX  = 25'h1FFFFFF;
    localparam logic [PROB_BITS-1:0] FLOOR_A   = 25'((16777216 + 5000) / 10000);
    localparam logic [13:0]          RATE_Q16  = 14'd9830;
    localparam logic [16:0]          FB_ONE    = 17'd65536;
    localparam logic [15:0]          LFSR_SEED = 16'hACE1;

    localparam logic [1:0] MODE_REWARD = 2'd0;
    localparam logic [1:0] MODE_TOUCH  = 2'd1;
    localparam logic [1:0] MODE_CHOOSE = 2'd2;

    localparam logic CFG_ITEM_COUNT = 1'b0;
    localparam logic CFG_ITEM_SIZES = 1'b1;

    typedef enum logic [13:0] {
        ST_IDLE  = 14'b00000000000001,
        ST_RRD   = 14'b00000000000010,
        ST_RMUL  = 14'b00000000000100,
        ST_RWR   = 14'b00000000001000,
        ST_FRD   = 14'b00000000010000,
        ST_FWR   = 14'b00000000100000,
        ST_SRD   = 14'b00000001000000,
        ST_SDT   = 14'b00000010000000,
        ST_SSQ   = 14'b00000100000000,
        ST_SM0   = 14'b00001000000000,
        ST_SM1   = 14'b00010000000000,
        ST_SCMP  = 14'b00100000000000,
        ST_SPICK = 14'b01000000000000,
        ST_OUT   = 14'b10000000000000
    } t_state;

    // floor(ONE / n) for the slot counts in use
    function automatic logic [PROB_BITS-1:0] equal_share(input logic [CNT_BITS-1:0] n);
        case (n)
            4'd1:    return 25'd16777216;
            4'd2:    return 25'd8388608;
            4'd3:    return 25'd5592405;
            4'd4:    return 25'd4194304;
            4'd5:    return 25'd3355443;
            4'd6:    return 25'd2796202;
            4'd7:    return 25'd2396745;
            4'd8:    return 25'd2097152;
            default: return 25'd0;
        endcase
    endfunction

    // 840 / size, with size nibble 0 read as 1 and above 8 as 8
    function automatic logic [SCALE_BITS-1:0] size_scale(input logic [3:0] nib);
        case (nib)
            4'd0, 4'd1: return 10'd840;
            4'd2:       return 10'd420;
            4'd3:       return 10'd280;
            4'd4:       return 10'd210;
            4'd5:       return 10'd168;
            4'd6:       return 10'd140;
            4'd7:       return 10'd120;
            default:    return 10'd105;
        endcase
    endfunction

    function automatic logic [15:0] lfsr_next(input logic [15:0] v);
        logic fb;
        fb = v[0] ^ v[2] ^ v[3] ^ v[5];
        return {fb, v[15:1]};
    endfunction

endpackage

// ----- rtl/core/las_req_if.sv -----
interface las_req_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 mode;
    logic [2:0]                 slot;
    logic [31:0]                tick_time;
    logic signed [17:0]         feedback;

    modport source (output valid, mode, slot, tick_time, feedback, input ready);
    modport sink   (input valid, mode, slot, tick_time, feedback, output ready);
endinterface

// ----- rtl/core/las_rsp_if.sv -----
interface las_rsp_if;
    logic       valid;
    logic       ready;
    logic       status;
    logic       found;
    logic [2:0] chosen_slot;

    modport source (output valid, status, found, chosen_slot, input ready);
    modport sink   (input valid, status, found, chosen_slot, output ready);
endinterface

// ----- rtl/core/learning_automaton_selector_top.sv -----
// Linear reward-inaction learning automaton over up to eight slots. Each
// request beat on i_req gives exactly one response beat on o_rsp. Reward
// (mode 0) pulls every other slot in use toward the floor probability and
// gives the total to the named slot, then stamps its tick; touch (mode 1)
// only stamps the tick; choose (mode 2) returns the slot of largest
// (t - last)^2 * p / size, ties split by a 16-bit LFSR, found = 0 when every
// weight is zero. A slot at or above item_count returns status 1 and changes
// nothing. Probabilities and ticks live in two synchronous memories, each
// with one write and one read port, walked one slot at a time. The time
// from one request beat to the next is set by the read / multiply /
// write-back sequence per slot: reward walks every other slot in use and
// choose every slot in use, while touch, a bad reward or touch slot or an
// unknown mode go straight to the response; a response still held by
// o_rsp.ready stretches this. A request beat is taken only while the
// sequencer idles; one finished response may wait in the output register
// while the next request is taken. Writing item_count (index 0) resets
// every slot to equal share and zero tick at once through per-entry valid
// bits, so there is no clearing pass; write configuration only while the block is idle.
module learning_automaton_selector_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    las_req_if.sink     i_req,
    las_rsp_if.source   o_rsp
);
    import las_pkg::*;

    // state memories
    logic [PROB_BITS-1:0] prob_mem [8];
    logic [TIME_BITS-1:0] tick_mem [8];

    t_state r_state, n_state;

    logic [CNT_BITS-1:0]  r_count;
    logic [31:0]          r_sizes;
    logic [15:0]          r_lfsr;
    logic [7:0]           r_pv, r_tv;

    logic [SLOT_BITS-1:0] r_slot;
    logic [TIME_BITS-1:0] r_t;
    logic [LF_BITS-1:0]   r_lf;
    logic [CNT_BITS-1:0]  r_idx;

    // read port outputs
    logic [PROB_BITS-1:0] r_prob_q;
    logic [TIME_BITS-1:0] r_tick_q;
    logic                 r_pv_q, r_tv_q;

    // reward datapath
    logic [PROB_BITS-1:0] r_p;
    logic                 r_below;
    logic [PROD_BITS-1:0] r_prod;
    logic [27:0]          r_gain, r_loss;

    // choose datapath
    logic [TIME_BITS-1:0]   r_dt;
    logic [PK_BITS-1:0]     r_pk;
    logic [2*TIME_BITS-1:0] r_dt2;
    logic [W_BITS-1:0]      r_w, r_best;
    logic [7:0]             r_mask;
    logic [CNT_BITS-1:0]    r_tcnt;

    // pending result and output register
    logic                 r_res_st, r_res_fd;
    logic [SLOT_BITS-1:0] r_res_ch;
    logic                 r_ov, r_ost, r_ofd;
    logic [SLOT_BITS-1:0] r_och;

    logic [SLOT_BITS-1:0] rd_addr;
    logic [PROB_BITS-1:0] p_cur;
    logic [TIME_BITS-1:0] t_cur;
    logic                 req_fire;
    logic [16:0]          fb_clamp;
    logic                 bad_slot;

    logic                 prob_we;
    logic [SLOT_BITS-1:0] prob_wa;
    logic [PROB_BITS-1:0] prob_wd;
    logic                 tick_we;
    logic [SLOT_BITS-1:0] tick_wa;
    logic [TIME_BITS-1:0] tick_wd;

    logic [PROB_BITS-1:0] dec;
    logic [PROB_BITS:0]   up_sum;
    logic [PROB_BITS-1:0] other_np;
    logic signed [29:0]   fin_sum;
    logic [PROB_BITS-1:0] fin_np;
    logic [PROB_BITS-1:0] dsub;

    logic [15:0]          lfsr_n;
    logic [19:0]          pick_prod;
    logic [CNT_BITS-1:0]  pick;
    logic [SLOT_BITS-1:0] pick_slot;
    logic [CNT_BITS-1:0]  pick_k;
    logic                 pick_hit;
    logic                 out_load;

    assign req_fire    = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == ST_IDLE);
    assign bad_slot    = ({1'b0, i_req.slot} >= r_count);

    assign rd_addr = (r_state == ST_FRD) ? r_slot : r_idx[SLOT_BITS-1:0];
    assign p_cur   = r_pv_q ? r_prob_q : equal_share(r_count);
    assign t_cur   = r_tv_q ? r_tick_q : '0;

    // clamp feedback to 0..1.0
    always_comb begin
        if (i_req.feedback[FB_BITS-1])
            fb_clamp = '0;
        else if (i_req.feedback[16:0] > FB_ONE || i_req.feedback[16])
            fb_clamp = FB_ONE;
        else
            fb_clamp = i_req.feedback[16:0];
    end

    // reward arithmetic: other slot update and final slot gain
    assign dec  = {2'b00, r_prod[PROD_BITS-1:32]};
    assign dsub = (p_cur < FLOOR_A) ? (FLOOR_A - p_cur) : (p_cur - FLOOR_A);
    always_comb begin
        up_sum = {1'b0, r_p} + {1'b0, dec};
        if (r_below)
            other_np = up_sum[PROB_BITS] ? PROB_MAX : up_sum[PROB_BITS-1:0];
        else
            other_np = r_p - dec;
        fin_sum = $signed({5'b0, p_cur}) + $signed({2'b0, r_gain})
                - $signed({2'b0, r_loss});
        if (fin_sum < 0)
            fin_np = '0;
        else if (fin_sum > $signed({5'b0, PROB_MAX}))
            fin_np = PROB_MAX;
        else
            fin_np = fin_sum[PROB_BITS-1:0];
    end

    // tie pick: index into the tied set after one LFSR step
    assign lfsr_n    = lfsr_next(r_lfsr);
    assign pick_prod = lfsr_n * r_tcnt;
    assign pick      = pick_prod[19:16];
    always_comb begin
        pick_slot = '0;
        pick_k    = '0;
        pick_hit  = 1'b0;
        for (int i = 0; i < 8; i++) begin
            if (r_mask[i] && !pick_hit) begin
                if (pick_k == pick) begin
                    pick_slot = SLOT_BITS'(i);
                    pick_hit  = 1'b1;
                end else begin
                    pick_k = pick_k + 1'b1;
                end
            end
        end
    end

    // memory write selection
    always_comb begin
        prob_we = 1'b0;
        prob_wa = r_idx[SLOT_BITS-1:0];
        prob_wd = other_np;
        tick_we = 1'b0;
        tick_wa = r_slot;
        tick_wd = r_t;
        if (r_state == ST_RWR) begin
            prob_we = 1'b1;
        end else if (r_state == ST_FWR) begin
            prob_we = 1'b1;
            prob_wa = r_slot;
            prob_wd = fin_np;
            tick_we = 1'b1;
        end else if (req_fire && i_req.mode == MODE_TOUCH && !bad_slot) begin
            tick_we = 1'b1;
            tick_wa = i_req.slot;
            tick_wd = i_req.tick_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (prob_we)
            prob_mem[prob_wa] <= prob_wd;
        if (tick_we)
            tick_mem[tick_wa] <= tick_wd;
        r_prob_q <= prob_mem[rd_addr];
        r_tick_q <= tick_mem[rd_addr];
        r_pv_q   <= r_pv[rd_addr];
        r_tv_q   <= r_tv[rd_addr];
    end

    assign out_load = (r_state == ST_OUT) && (!r_ov || o_rsp.ready);

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (req_fire) begin
                    if (i_req.mode == MODE_REWARD && !bad_slot)
                        n_state = ST_RRD;
                    else if (i_req.mode == MODE_CHOOSE)
                        n_state = ST_SRD;
                    else
                        n_state = ST_OUT;
                end
            end
            ST_RRD: begin
                if (r_idx == r_count)
                    n_state = ST_FRD;
                else if (r_idx[SLOT_BITS-1:0] != r_slot)
                    n_state = ST_RMUL;
            end
            ST_RMUL:  n_state = ST_RWR;
            ST_RWR:   n_state = ST_RRD;
            ST_FRD:   n_state = ST_FWR;
            ST_FWR:   n_state = ST_OUT;
            ST_SRD:   n_state = ST_SDT;
            ST_SDT:   n_state = ST_SSQ;
            ST_SSQ:   n_state = ST_SM0;
            ST_SM0:   n_state = ST_SM1;
            ST_SM1:   n_state = ST_SCMP;
            ST_SCMP:  n_state = (r_idx + 1'b1 == r_count) ? ST_SPICK : ST_SRD;
            ST_SPICK: n_state = ST_OUT;
            ST_OUT:   n_state = out_load ? ST_IDLE : ST_OUT;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= 4'd1;
            r_sizes <= 32'h11111111;
            r_lfsr  <= LFSR_SEED;
            r_pv    <= '0;
            r_tv    <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_ITEM_COUNT) begin
                    if (i_cfg_data[3:0] == 4'd0)
                        r_count <= 4'd1;
                    else if (i_cfg_data[3:0] > MAX_SLOTS)
                        r_count <= MAX_SLOTS;
                    else
                        r_count <= i_cfg_data[3:0];
                    // drop every stored entry back to equal share, zero tick
                    r_pv <= '0;
                    r_tv <= '0;
                end else begin
                    r_sizes <= i_cfg_data;
                end
            end else begin
                if (prob_we)
                    r_pv[prob_wa] <= 1'b1;
                if (tick_we)
                    r_tv[tick_wa] <= 1'b1;
            end

            if (r_state == ST_SPICK && r_best != '0)
                r_lfsr <= lfsr_n;

            if (out_load)
                r_ov <= 1'b1;
            else if (o_rsp.ready)
                r_ov <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_slot   <= i_req.slot;
                r_t      <= i_req.tick_time;
                r_lf     <= LF_BITS'({13'd0, fb_clamp} * RATE_Q16);
                r_idx    <= '0;
                r_gain   <= '0;
                r_loss   <= '0;
                r_best   <= '0;
                r_mask   <= '0;
                r_tcnt   <= '0;
                r_res_st <= (i_req.mode == MODE_REWARD || i_req.mode == MODE_TOUCH)
                            && bad_slot;
                r_res_fd <= 1'b0;
                r_res_ch <= '0;
            end
            ST_RRD: begin
                if (r_idx != r_count && r_idx[SLOT_BITS-1:0] == r_slot)
                    r_idx <= r_idx + 1'b1;
            end
            ST_RMUL: begin
                r_p     <= p_cur;
                r_below <= (p_cur < FLOOR_A);
                r_prod  <= dsub * r_lf;
            end
            ST_RWR: begin
                if (r_below)
                    r_loss <= r_loss + 28'(dec);
                else
                    r_gain <= r_gain + 28'(dec);
                r_idx <= r_idx + 1'b1;
            end
            ST_SDT: begin
                r_dt <= (r_t >= t_cur) ? (r_t - t_cur) : (t_cur - r_t);
                r_pk <= p_cur * size_scale(r_sizes[r_idx[SLOT_BITS-1:0]*4 +: 4]);
            end
            ST_SSQ: r_dt2 <= r_dt * r_dt;
            ST_SM0: r_w <= W_BITS'({35'd0, r_dt2[31:0]} * r_pk);
            ST_SM1: r_w <= r_w + (W_BITS'({35'd0, r_dt2[63:32]} * r_pk) << 32);
            ST_SCMP: begin
                if (r_w > r_best) begin
                    r_best <= r_w;
                    r_mask <= 8'(1) << r_idx[SLOT_BITS-1:0];
                    r_tcnt <= 4'd1;
                end else if (r_w == r_best) begin
                    r_mask[r_idx[SLOT_BITS-1:0]] <= 1'b1;
                    r_tcnt <= r_tcnt + 1'b1;
                end
                r_idx <= r_idx + 1'b1;
            end
            ST_SPICK: begin
                if (r_best != '0) begin
                    r_res_fd <= 1'b1;
                    r_res_ch <= pick_slot;
                end
            end
            default: ;
        endcase

        if (out_load) begin
            r_ost <= r_res_st;
            r_ofd <= r_res_fd;
            r_och <= r_res_ch;
        end
    end

    assign o_rsp.valid       = r_ov;
    assign o_rsp.status      = r_ost;
    assign o_rsp.found       = r_ofd;
    assign o_rsp.chosen_slot = r_och;

endmodule

// ----- bench/tb_learning_automaton_selector_top.sv -----
module tb_learning_automaton_selector_top;
    import las_pkg::*;

    // One response beat as the block should present it.
    typedef struct {
        logic       status;
        logic       found;
        logic [2:0] chosen_slot;
    } t_reply;

    // Bit-exact model of the automaton plus the queue of replies it predicts.
    class slot_automaton_model;
        logic [PROB_BITS-1:0] prob[8];
        logic [31:0]          last_used[8];
        logic [15:0]          tie_shift;
        int unsigned          slots_in_use;
        logic [31:0]          size_word;
        t_reply               expected_replies[$];
        int unsigned          errors;

        function void equalize();
            for (int i = 0; i < 8; i++) begin
                prob[i]      = (i < slots_in_use) ?
                               PROB_BITS'(PROB_ONE / slots_in_use) : '0;
                last_used[i] = '0;
            end
        endfunction

        function void clear();
            slots_in_use = 1;
            size_word    = 32'h11111111;
            tie_shift    = LFSR_SEED;
            errors       = 0;
            equalize();
        endfunction

        function void write_reg(logic idx, logic [31:0] data);
            int unsigned n;
            if (idx == CFG_ITEM_COUNT) begin
                n = 32'(data[3:0]);
                if (n == 0) n = 1;
                if (n > 8) n = 8;
                slots_in_use = n;
                equalize();
            end else begin
                size_word = data;
            end
        endfunction

        function logic [127:0] weight(int i, logic [31:0] t);
            logic [127:0] dt;
            int unsigned  sz;
            sz = 32'(size_word[4*i +: 4]);
            if (sz == 0) sz = 1;
            if (sz > 8) sz = 8;
            dt = 128'((t >= last_used[i]) ? t - last_used[i] : last_used[i] - t);
            return dt * dt * 128'(prob[i]) * 128'(840 / sz);
        endfunction

        // Work out the reply to one accepted request and update the state.
        function void note_request(logic [1:0] mode, logic [2:0] slot, logic [31:0] t,
                                   logic signed [17:0] fb);
            t_reply      r;
            logic [63:0] f, lf, gain, loss, p, d, np, a_floor;
            logic [127:0] best, w;
            int unsigned tied, pick, k;
            r = '{1'b0, 1'b0, 3'd0};
            a_floor = (64'd16777216 + 64'd5000) / 64'd10000;
            if (mode == MODE_REWARD || mode == MODE_TOUCH) begin
                if (slot >= slots_in_use) begin
                    r.status = 1'b1;
                end else begin
                    if (mode == MODE_REWARD) begin
                        // negative feedback counts as none, above one as one
                        f = fb[17] ? 64'd0 : ((fb > 65536) ? 64'd65536 : 64'(fb));
                        lf = 64'd9830 * f;
                        gain = 0;
                        loss = 0;
                        for (int j = 0; j < slots_in_use; j++) begin
                            if (j == slot) continue;
                            p = 64'(prob[j]);
                            if (p >= a_floor) begin
                                d = ((p - a_floor) * lf) >> 32;
                                prob[j] = PROB_BITS'(p - d);
                                gain += d;
                            end else begin
                                d = ((a_floor - p) * lf) >> 32;
                                np = p + d;
                                prob[j] = (np > PROB_MAX) ? PROB_MAX : PROB_BITS'(np);
                                loss += d;
                            end
                        end
                        np = 64'(prob[slot]) + gain;
                        np = (np < loss) ? 64'd0 : np - loss;
                        prob[slot] = (np > PROB_MAX) ? PROB_MAX : PROB_BITS'(np);
                    end
                    last_used[slot] = t;
                end
            end else if (mode == MODE_CHOOSE) begin
                best = '0;
                for (int i = 0; i < slots_in_use; i++) begin
                    w = weight(i, t);
                    if (w > best) best = w;
                end
                if (best != 0) begin
                    tied = 0;
                    for (int i = 0; i < slots_in_use; i++)
                        if (weight(i, t) == best) tied++;
                    tie_shift = {tie_shift[0] ^ tie_shift[2] ^ tie_shift[3] ^ tie_shift[5],
                                 tie_shift[15:1]};
                    pick = (32'(tie_shift) * tied) >> 16;
                    k = 0;
                    for (int i = 0; i < slots_in_use; i++) begin
                        if (weight(i, t) == best) begin
                            if (k == pick) begin
                                r.found = 1'b1;
                                r.chosen_slot = i[2:0];
                                break;
                            end
                            k++;
                        end
                    end
                end
            end
            expected_replies = {expected_replies, r};
        endfunction

        task report(string what);
            $display("mismatch: %s", what);
            errors++;
        endtask

        task check_reply(t_reply got);
            t_reply want;
            if (expected_replies.size() == 0) begin
                report("response beat with nothing pending");
                return;
            end
            want = expected_replies.pop_front();
            if (got.status !== want.status)
                report($sformatf("status %b, want %b", got.status, want.status));
            if (got.found !== want.found)
                report($sformatf("found %b, want %b", got.found, want.found));
            if (got.chosen_slot !== want.chosen_slot)
                report($sformatf("chosen_slot %0d, want %0d", got.chosen_slot,
                                 want.chosen_slot));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [31:0] i_cfg_data;

    las_req_if req_ch();
    las_rsp_if rsp_ch();

    learning_automaton_selector_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch)
    );

    slot_automaton_model automaton = new();
    bit          calm;          // set: neither side idles
    int unsigned quiet_cycles;
    logic [31:0] now_tick;

    localparam int QUIET_LIMIT = 4000;

    always #10 i_clk = ~i_clk;

    // Drive all inputs to known values before the first edge.
    initial begin
        i_clk            = 1'b0;
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = CFG_ITEM_COUNT;
        i_cfg_data       = '0;
        req_ch.valid     = 1'b0;
        req_ch.mode      = MODE_REWARD;
        req_ch.slot      = '0;
        req_ch.tick_time = '0;
        req_ch.feedback  = '0;
        rsp_ch.ready     = 1'b0;
        calm             = 1'b0;
        quiet_cycles     = 0;
        automaton.clear();
    end

    // Sample both handshakes at the falling edge, where everything is settled;
    // a beat seen here is taken at the next rising edge. The same loop runs
    // the watchdog and randomizes the response-side ready.
    always begin
        @(negedge i_clk);
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready)
            automaton.check_reply('{rsp_ch.status, rsp_ch.found, rsp_ch.chosen_slot});
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles = 0;
        else if (i_rst_n)
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("** learning_automaton_selector_top: FAILED **");
            $finish;
        end
        @(posedge i_clk);
        if (i_rst_n)
            rsp_ch.ready <= calm || ($urandom_range(99) >= 10);
    end

    // Send one request beat; idle now and then first. Leave valid high so
    // the next beat follows back to back.
    task automatic send_beat(logic [1:0] mode, logic [2:0] slot, logic [31:0] t,
                             logic signed [17:0] fb);
        while (!calm && $urandom_range(99) < 10) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.mode      <= mode;
        req_ch.slot      <= slot;
        req_ch.tick_time <= t;
        req_ch.feedback  <= fb;
        @(negedge i_clk);
        while (!req_ch.ready) begin
            @(posedge i_clk);
            @(negedge i_clk);
        end
        automaton.note_request(mode, slot, t, fb);
        @(posedge i_clk);
    endtask

    // Drop valid and hold until every pending reply is back, then let the
    // sequencer settle before touching configuration.
    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (automaton.expected_replies.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        automaton.write_reg(idx, data);
        @(posedge i_clk);
    endtask

    // Mostly well-formed traffic on slots in use, with time moving forward.
    task automatic random_beats(int n);
        logic [1:0]         mode;
        logic [2:0]         slot;
        logic [31:0]        t;
        logic signed [17:0] fb;
        int unsigned        roll;
        for (int i = 0; i < n; i++) begin
            roll = $urandom_range(99);
            mode = (roll < 45) ? MODE_REWARD : (roll < 60) ? MODE_TOUCH :
                   (roll < 95) ? MODE_CHOOSE : 2'd3;
            slot = ($urandom_range(99) < 80) ?
                   3'($urandom_range(automaton.slots_in_use - 1)) : 3'($urandom_range(7));
            now_tick += $urandom_range(40);
            t = ($urandom_range(99) < 10) ? $urandom() : now_tick;
            roll = $urandom_range(99);
            fb = (roll < 60) ? 18'($urandom_range(65536)) :
                 (roll < 80) ? 18'($urandom()) :
                 (roll < 90) ? 18'sd65536 : 18'sd131071;
            send_beat(mode, slot, t, fb);
        end
    endtask

    initial begin
        logic [31:0] counts[8];
        logic [31:0] sizes[8];
        counts = '{32'd8, 32'd3, 32'd5, 32'd2, 32'd0, 32'd7, 32'd15, 32'd4};
        sizes  = '{32'h11111111, 32'hFFFFFFFF, 32'h00000000, 32'h12345678,
                   32'h8F0A3C91, 32'h87654321, 32'h22222222, 32'h0};
        now_tick = 0;

        // hold reset, then release
        repeat (8) @(posedge i_clk);
        i_rst_n      <= 1'b1;
        rsp_ch.ready <= 1'b1;
        @(posedge i_clk);

        // Directed: single slot after reset, zero weights, bad slot, unknown mode.
        send_beat(MODE_CHOOSE, 3'd0, 32'd0, 18'sd0);
        send_beat(MODE_REWARD, 3'd0, 32'd5, 18'sd65536);
        send_beat(MODE_TOUCH, 3'd1, 32'd6, 18'sd0);
        send_beat(2'd3, 3'd7, 32'hFFFFFFFF, -18'sd1);
        send_beat(MODE_CHOOSE, 3'd4, 32'd9, 18'sd0);
        drain();

        // Directed: all eight slots, ties, feedback extremes, time going backward.
        write_reg(CFG_ITEM_SIZES, 32'h11111111);
        write_reg(CFG_ITEM_COUNT, 32'd8);
        send_beat(MODE_CHOOSE, 3'd0, 32'd0, 18'sd0);
        send_beat(MODE_CHOOSE, 3'd0, 32'd100, 18'sd0);
        send_beat(MODE_CHOOSE, 3'd0, 32'd100, 18'sd0);
        send_beat(MODE_REWARD, 3'd3, 32'd200, 18'sd131071);
        send_beat(MODE_REWARD, 3'd3, 32'd201, -18'sd131072);
        send_beat(MODE_REWARD, 3'd5, 32'd202, 18'sd0);
        send_beat(MODE_REWARD, 3'd7, 32'hFFFFFFFF, 18'sd65536);
        for (int i = 0; i < 5; i++)
            send_beat(MODE_REWARD, 3'd0, 32'd300 + i, 18'sd65536);
        send_beat(MODE_TOUCH, 3'd7, 32'd0, 18'sd0);
        send_beat(MODE_CHOOSE, 3'd0, 32'd50, 18'sd0);
        send_beat(MODE_CHOOSE, 3'd0, 32'hFFFFFFFF, 18'sd0);
        drain();

        // Random phases, each under a fresh register setting.
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(CFG_ITEM_SIZES, (ph == 7) ? $urandom() : sizes[ph]);
            write_reg(CFG_ITEM_COUNT, counts[ph]);
            now_tick = 0;
            calm = (ph == 2);
            random_beats(50);
            drain();
        end
        calm = 1'b0;

        repeat (60) @(posedge i_clk);
        if (automaton.errors == 0)
            $display("** learning_automaton_selector_top: PASSED **");
        else
            $display("** learning_automaton_selector_top: FAILED **");
        $finish;
    end

endmodule
